@@ hdl/boot_lfsr_sync_handshake_core_assert.svh @@
// ----------------------------------------------------------------------------
// Boot sync handshake assertion macros
// Clocked concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOOT_LFSR_SYNC_HANDSHAKE_CORE_ASSERT_SVH
`define BOOT_LFSR_SYNC_HANDSHAKE_CORE_ASSERT_SVH

`ifndef SYNTH
`define BLS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("boot sync handshake check failed");
`define BLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("boot sync handshake check failed");
`else
`define BLS_ASSERT_NOW(lbl, ante, cons)
`define BLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake package
// Shared constants, codes and types of the boot sync handshake core.
// ----------------------------------------------------------------------------
package bls_pkg;

	localparam int SYNC_BITS   = 250;
	localparam int CLOCK_BYTES = 258;
	localparam int TX_TOTAL    = 1 + SYNC_BITS + CLOCK_BYTES;
	localparam int TX_POS_W    = $clog2(TX_TOTAL);
	localparam int RX_POS_W    = $clog2(SYNC_BITS);
	localparam int VER_BITS    = 8;

	localparam logic [7:0] LFSR_SEED = 8'd80;
	localparam logic [7:0] CAL_BYTE  = 8'hF9;
	localparam logic [6:0] LFSR_FILL = 7'h7F;

	localparam logic [1:0] RETRY_LIMIT_RST   = 2'd1;
	localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd100;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_TX_REQ  = 2'd1,
		CMD_RX_BYTE = 2'd2,
		CMD_TIMEOUT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SEND  = 3'd1,
		PH_CHECK = 3'd2,
		PH_VER   = 3'd3,
		PH_FOUND = 3'd4,
		PH_NONE  = 3'd5
	} phase_t;

	typedef enum logic [0:0] {
		CFG_RETRY_LIMIT   = 1'b0,
		CFG_TIMEOUT_LIMIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]          lfsr;
		phase_t              phase;
		logic [TX_POS_W-1:0] tx_pos;
		logic [RX_POS_W-1:0] rx_pos;
		logic [7:0]          tmo_cnt;
		logic [1:0]          retries;
		logic [7:0]          ver_shift;
		logic                first_seen;
	} state_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       reset_request;
		logic [2:0] status;
		logic [7:0] version;
	} result_t;

	typedef struct packed {
		logic [1:0] command;
		logic       rx_bit;
	} item_t;

endpackage

@@ hdl/bls_if.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface bls_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface bls_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       reset_request;
	logic [2:0] status;
	logic [7:0] version;

	modport source (output valid, output tx_byte, output tx_valid, output reset_request,
		output status, output version, input ready);
	modport sink (input valid, input tx_byte, input tx_valid, input reset_request,
		input status, input version, output ready);
endinterface

@@ hdl/bls_in_reg.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake input register
// Capture a command beat and hold it until the engine consumes it.
// ----------------------------------------------------------------------------
module bls_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	bls_cmd_if.sink       cmd_in,
	input  logic          adv,
	output logic          valid_s1,
	output bls_pkg::item_t item_s1
);

	assign cmd_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			valid_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.ready && cmd_in.valid) begin
			item_s1.command <= cmd_in.command;
			item_s1.rx_bit  <= cmd_in.rx_byte[0];
		end
	end

endmodule

@@ hdl/bls_engine.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake engine
// Handshake state and the combinational next-state update for one command beat.
// ----------------------------------------------------------------------------
module bls_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  bls_pkg::item_t  item,
	input  logic [1:0]      retry_limit,
	input  logic [7:0]      timeout_limit,
	output bls_pkg::result_t res,
	output bls_pkg::phase_t phase
);

	bls_pkg::state_t st_q;
	bls_pkg::state_t nxt;
	logic [7:0]      lfsr_adv;
	logic            lfsr_out;
	logic [7:0]      ver_new;

	assign lfsr_out = st_q.lfsr[0];
	assign lfsr_adv = {st_q.lfsr[6:0],
		st_q.lfsr[7] ^ st_q.lfsr[5] ^ st_q.lfsr[4] ^ st_q.lfsr[1]};
	assign ver_new  = {item.rx_bit, st_q.ver_shift[7:1]};
	assign phase    = st_q.phase;

	always_comb begin
		nxt               = st_q;
		res.tx_byte       = 8'd0;
		res.tx_valid      = 1'b0;
		res.reset_request = 1'b0;
		case (item.command)
			bls_pkg::CMD_START: begin
				nxt.lfsr       = bls_pkg::LFSR_SEED;
				nxt.phase      = bls_pkg::PH_SEND;
				nxt.tx_pos     = '0;
				nxt.rx_pos     = '0;
				nxt.tmo_cnt    = 8'd0;
				nxt.ver_shift  = 8'd0;
				nxt.first_seen = 1'b0;
				nxt.retries    = retry_limit;
			end
			bls_pkg::CMD_TX_REQ: begin
				if (st_q.phase == bls_pkg::PH_SEND) begin
					res.tx_valid = 1'b1;
					if (st_q.tx_pos == '0) begin
						res.tx_byte = bls_pkg::CAL_BYTE;
					end else if (st_q.tx_pos <= bls_pkg::TX_POS_W'(bls_pkg::SYNC_BITS)) begin
						res.tx_byte = {bls_pkg::LFSR_FILL, lfsr_out};
						nxt.lfsr    = lfsr_adv;
					end else begin
						res.tx_byte = bls_pkg::CAL_BYTE;
					end
					nxt.tx_pos = st_q.tx_pos + 1'b1;
					if (st_q.tx_pos == bls_pkg::TX_POS_W'(bls_pkg::TX_TOTAL - 1)) begin
						nxt.phase      = bls_pkg::PH_CHECK;
						nxt.rx_pos     = '0;
						nxt.tmo_cnt    = 8'd0;
						nxt.first_seen = 1'b0;
					end
				end
			end
			bls_pkg::CMD_RX_BYTE: begin
				if (st_q.phase == bls_pkg::PH_CHECK) begin
					nxt.lfsr = lfsr_adv;
					if (item.rx_bit != lfsr_out) begin
						if (st_q.retries != 2'd0) begin
							nxt.retries       = st_q.retries - 2'd1;
							res.reset_request = 1'b1;
							nxt.lfsr          = bls_pkg::LFSR_SEED;
							nxt.phase         = bls_pkg::PH_SEND;
							nxt.tx_pos        = '0;
							nxt.rx_pos        = '0;
							nxt.tmo_cnt       = 8'd0;
							nxt.ver_shift     = 8'd0;
							nxt.first_seen    = 1'b0;
						end else begin
							nxt.phase = bls_pkg::PH_NONE;
						end
					end else begin
						nxt.first_seen = 1'b1;
						nxt.tmo_cnt    = 8'd0;
						if (st_q.rx_pos == bls_pkg::RX_POS_W'(bls_pkg::SYNC_BITS - 1)) begin
							nxt.phase     = bls_pkg::PH_VER;
							nxt.rx_pos    = '0;
							nxt.ver_shift = 8'd0;
						end else begin
							nxt.rx_pos = st_q.rx_pos + 1'b1;
						end
					end
				end else if (st_q.phase == bls_pkg::PH_VER) begin
					nxt.ver_shift = ver_new;
					nxt.rx_pos    = st_q.rx_pos + 1'b1;
					if (st_q.rx_pos == bls_pkg::RX_POS_W'(bls_pkg::VER_BITS - 1)) begin
						nxt.phase = (ver_new != 8'd0) ? bls_pkg::PH_FOUND : bls_pkg::PH_NONE;
					end
				end
			end
			bls_pkg::CMD_TIMEOUT: begin
				if (st_q.phase == bls_pkg::PH_CHECK) begin
					if (!st_q.first_seen || st_q.tmo_cnt >= timeout_limit) begin
						nxt.phase = bls_pkg::PH_NONE;
					end else begin
						nxt.tmo_cnt = st_q.tmo_cnt + 8'd1;
					end
				end
			end
			default: begin
				nxt = st_q;
			end
		endcase
		res.status  = nxt.phase;
		res.version = (nxt.phase == bls_pkg::PH_FOUND) ? nxt.ver_shift : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.lfsr       <= bls_pkg::LFSR_SEED;
			st_q.phase      <= bls_pkg::PH_IDLE;
			st_q.tx_pos     <= '0;
			st_q.rx_pos     <= '0;
			st_q.tmo_cnt    <= 8'd0;
			st_q.retries    <= 2'd0;
			st_q.ver_shift  <= 8'd0;
			st_q.first_seen <= 1'b0;
		end else if (en) begin
			st_q <= nxt;
		end
	end

endmodule

@@ hdl/bls_out_reg.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake result register
// Hold a result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bls_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bls_pkg::result_t res,
	output logic             can_load,
	bls_res_if.source        res_out
);

	bls_pkg::result_t res_q;
	logic             valid_q;

	assign can_load = !valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign res_out.valid         = valid_q;
	assign res_out.tx_byte       = res_q.tx_byte;
	assign res_out.tx_valid      = res_q.tx_valid;
	assign res_out.reset_request = res_q.reset_request;
	assign res_out.status        = res_q.status;
	assign res_out.version       = res_q.version;

endmodule

@@ hdl/boot_lfsr_sync_handshake_core.sv @@
// The core takes one command beat per clock while the result channel does not stall, and
// returns exactly one result beat for each. An accepted beat is held in the input register
// while the combinational state update runs on it, and the update is written to the result
// register, which presents the result beat. Throughput is one beat per cycle while the
// result channel does not stall. While the result channel stalls, the result register and
// the input register each hold one beat, and the input then stalls.
// ----------------------------------------------------------------------------
// Boot sync handshake core
// Host side of a serial boot sync handshake with LFSR check and version read.
// ----------------------------------------------------------------------------
`include "boot_lfsr_sync_handshake_core_assert.svh"

module boot_lfsr_sync_handshake_core (
	input  logic       clk,
	input  logic       arst_n,
	bls_cmd_if.sink    cmd_in,
	bls_res_if.source  res_out,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic             valid_s1;
	bls_pkg::item_t   item_s1;
	logic             can_load;
	logic             adv;
	bls_pkg::result_t res;
	bls_pkg::phase_t  phase;
	logic [1:0]       retry_limit_q;
	logic [7:0]       timeout_limit_q;
	logic             res_send;
	logic             res_check;
	logic             res_found;

	assign adv = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q   <= bls_pkg::RETRY_LIMIT_RST;
			timeout_limit_q <= bls_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bls_pkg::CFG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata[1:0];
				bls_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata;
				default: begin
					retry_limit_q <= retry_limit_q;
				end
			endcase
		end
	end

	bls_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd_in),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bls_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv),
		.item          (item_s1),
		.retry_limit   (retry_limit_q),
		.timeout_limit (timeout_limit_q),
		.res           (res),
		.phase         (phase)
	);

	bls_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.can_load (can_load),
		.res_out  (res_out)
	);

	assign res_send  = (res_out.status == bls_pkg::PH_SEND);
	assign res_check = (res_out.status == bls_pkg::PH_CHECK);
	assign res_found = (res_out.status == bls_pkg::PH_FOUND);

	`BLS_ASSERT_NOW(a_rreq_sending, res_out.valid && res_out.reset_request, res_send)
	`BLS_ASSERT_NOW(a_tx_phase, res_out.valid && res_out.tx_valid, res_send || res_check)
	`BLS_ASSERT_NOW(a_ver_found, res_out.valid && res_out.version != 8'd0, res_found)
	`BLS_ASSERT_NEXT(a_hold_s1, valid_s1 && !can_load, valid_s1 && $stable(phase))

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Boot sync handshake core testbench
// Drives command beats through the valid/ready channel and predicts every
// result beat from the directed table or a cycle-free handshake model: LFSR
// stream, response check, timeouts, retries and version read. A short table
// of directed beats is followed by short sessions of random commands and one
// whole handshake session with random content and noise, under several
// register settings, random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CFG  = -1;

	typedef enum int {
		S_FULL,
		S_VER_ZERO,
		S_MISMATCH,
		S_FIRST_TIMEOUT,
		S_TIMEOUT_LIMIT,
		S_RESTART,
		S_BROKEN
	} session_kind_t;

	typedef struct packed {
		bls_pkg::cmd_t    cmd;
		logic [7:0]       rxb;
		logic             typed;
		bls_pkg::result_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;

	bls_cmd_if cmd_bus ();
	bls_res_if res_bus ();

	boot_lfsr_sync_handshake_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_bus),
		.res_out   (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [1:0]      retry_lim_q;
	logic [7:0]      tmo_lim_q;
	logic [7:0]      lfsr_q;
	bls_pkg::phase_t phase_q;
	int              tx_pos_q;
	int              rx_pos_q;
	logic [7:0]      tmo_cnt_q;
	logic [1:0]      retries_q;
	logic [7:0]      ver_shift_q;
	bit              first_seen_q;

	bls_pkg::result_t handshake_results_due [$];
	int               fail_count;
	int               beats_sent;
	int               cycle_count;
	bit               tx_quiet;
	bit               hold_off;

	dir_row_t dir_rows [14] = '{
		'{bls_pkg::CMD_TX_REQ,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_IDLE, 8'h00}},
		'{bls_pkg::CMD_RX_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_IDLE, 8'h00}},
		'{bls_pkg::CMD_RX_BYTE, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_IDLE, 8'h00}},
		'{bls_pkg::CMD_TIMEOUT, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_IDLE, 8'h00}},
		'{bls_pkg::CMD_START,   8'hA5, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_SEND, 8'h00}},
		'{bls_pkg::CMD_TX_REQ,  8'h5A, 1'b1,
			'{bls_pkg::CAL_BYTE, 1'b1, 1'b0, bls_pkg::PH_SEND, 8'h00}},
		'{bls_pkg::CMD_TX_REQ,  8'h00, 1'b0, '0},
		'{bls_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, '0},
		'{bls_pkg::CMD_TIMEOUT, 8'hFF, 1'b0, '0},
		'{bls_pkg::CMD_TX_REQ,  8'hFF, 1'b0, '0},
		'{bls_pkg::CMD_START,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_SEND, 8'h00}},
		'{bls_pkg::CMD_TX_REQ,  8'h00, 1'b1,
			'{bls_pkg::CAL_BYTE, 1'b1, 1'b0, bls_pkg::PH_SEND, 8'h00}},
		'{bls_pkg::CMD_TX_REQ,  8'h80, 1'b0, '0},
		'{bls_pkg::CMD_START,   8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, bls_pkg::PH_SEND, 8'h00}}
	};

	session_kind_t plan_kind [4] = '{S_BROKEN, S_FULL, S_BROKEN, S_BROKEN};
	int plan_retry [4] = '{RANDOM_CFG, 3, RANDOM_CFG, RANDOM_CFG};
	int plan_tmo [4] = '{RANDOM_CFG, 2, RANDOM_CFG, RANDOM_CFG};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom);
	endfunction

	function automatic bit lfsr_advance();
		bit out_bit;
		out_bit = lfsr_q[0];
		lfsr_q = {lfsr_q[6:0], lfsr_q[7] ^ lfsr_q[5] ^ lfsr_q[4] ^ lfsr_q[1]};
		return out_bit;
	endfunction

	function automatic void restart_stream();
		lfsr_q = bls_pkg::LFSR_SEED;
		phase_q = bls_pkg::PH_SEND;
		tx_pos_q = 0;
		rx_pos_q = 0;
		tmo_cnt_q = '0;
		ver_shift_q = '0;
		first_seen_q = 1'b0;
	endfunction

	function automatic bls_pkg::result_t handshake_next(input bls_pkg::cmd_t cmd,
		input logic [7:0] rxb);
		bls_pkg::result_t res;
		bit want_bit;
		res = '0;
		case (cmd)
			bls_pkg::CMD_START: begin
				restart_stream();
				retries_q = retry_lim_q;
			end
			bls_pkg::CMD_TX_REQ: begin
				if (phase_q == bls_pkg::PH_SEND) begin
					if (tx_pos_q == 0 || tx_pos_q > bls_pkg::SYNC_BITS)
						res.tx_byte = bls_pkg::CAL_BYTE;
					else
						res.tx_byte = {bls_pkg::LFSR_FILL, lfsr_advance()};
					res.tx_valid = 1'b1;
					tx_pos_q++;
					if (tx_pos_q >= bls_pkg::TX_TOTAL) begin
						phase_q = bls_pkg::PH_CHECK;
						rx_pos_q = 0;
						tmo_cnt_q = '0;
						first_seen_q = 1'b0;
					end
				end
			end
			bls_pkg::CMD_RX_BYTE: begin
				if (phase_q == bls_pkg::PH_CHECK) begin
					want_bit = lfsr_advance();
					if (rxb[0] != want_bit) begin
						if (retries_q != 2'd0) begin
							retries_q = retries_q - 2'd1;
							res.reset_request = 1'b1;
							restart_stream();
						end else begin
							phase_q = bls_pkg::PH_NONE;
						end
					end else begin
						first_seen_q = 1'b1;
						tmo_cnt_q = '0;
						rx_pos_q++;
						if (rx_pos_q >= bls_pkg::SYNC_BITS) begin
							phase_q = bls_pkg::PH_VER;
							rx_pos_q = 0;
							ver_shift_q = '0;
						end
					end
				end else if (phase_q == bls_pkg::PH_VER) begin
					ver_shift_q = {rxb[0], ver_shift_q[7:1]};
					rx_pos_q++;
					if (rx_pos_q >= bls_pkg::VER_BITS)
						phase_q = (ver_shift_q != 8'd0) ? bls_pkg::PH_FOUND : bls_pkg::PH_NONE;
				end
			end
			default: begin
				if (phase_q == bls_pkg::PH_CHECK) begin
					if (!first_seen_q)
						phase_q = bls_pkg::PH_NONE;
					else if (tmo_cnt_q >= tmo_lim_q)
						phase_q = bls_pkg::PH_NONE;
					else
						tmo_cnt_q = tmo_cnt_q + 8'd1;
				end
			end
		endcase
		res.status = phase_q;
		res.version = (phase_q == bls_pkg::PH_FOUND) ? ver_shift_q : 8'd0;
		return res;
	endfunction

	task automatic send_beat(input bls_pkg::cmd_t cmd, input logic [7:0] rxb,
		input bit typed = 1'b0, input bls_pkg::result_t typed_res = '0);
		int gap;
		bls_pkg::result_t res;
		if (beats_sent % 50 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= cmd;
		cmd_bus.rx_byte <= rxb;
		do @(posedge clk); while (!cmd_bus.ready);
		res = handshake_next(cmd, rxb);
		handshake_results_due.push_back(typed ? typed_res : res);
		beats_sent++;
	endtask

	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (handshake_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input bls_pkg::cfg_idx_t idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bls_pkg::CFG_RETRY_LIMIT)
			retry_lim_q = value[1:0];
		else
			tmo_lim_q = value;
		@(posedge clk);
	endtask

	task automatic run_session(input session_kind_t kind);
		int mism_at;
		int tmo_at;
		int restart_at;
		int k;
		bit mism_done;
		bit restart_done;
		logic [7:0] ver_val;
		mism_at = $urandom_range(0, bls_pkg::SYNC_BITS - 1);
		tmo_at = $urandom_range(1, bls_pkg::SYNC_BITS - 1);
		restart_at = $urandom_range(0, bls_pkg::SYNC_BITS - 1);
		ver_val = (kind == S_VER_ZERO) ? 8'h00 : 8'($urandom_range(1, 255));
		mism_done = 1'b0;
		restart_done = 1'b0;
		send_beat(bls_pkg::CMD_START, rnd_byte());
		if (kind == S_BROKEN) begin
			repeat ($urandom_range(0, 24)) send_beat(bls_pkg::CMD_TX_REQ, rnd_byte());
			repeat ($urandom_range(4, 12))
				send_beat(bls_pkg::cmd_t'(2'($urandom_range(0, 3))), rnd_byte());
			return;
		end
		while (phase_q != bls_pkg::PH_FOUND && phase_q != bls_pkg::PH_NONE) begin
			k = $urandom_range(0, 15);
			case (phase_q)
				bls_pkg::PH_SEND: begin
					if (k == 0)
						send_beat(bls_pkg::CMD_RX_BYTE, rnd_byte());
					else if (k == 1)
						send_beat(bls_pkg::CMD_TIMEOUT, rnd_byte());
					else
						send_beat(bls_pkg::CMD_TX_REQ, rnd_byte());
				end
				bls_pkg::PH_CHECK: begin
					if (kind == S_FIRST_TIMEOUT && !first_seen_q) begin
						send_beat(bls_pkg::CMD_TIMEOUT, rnd_byte());
					end else if (kind == S_MISMATCH && !mism_done && rx_pos_q == mism_at) begin
						mism_done = 1'b1;
						send_beat(bls_pkg::CMD_RX_BYTE, {7'($urandom), ~lfsr_q[0]});
					end else if (kind == S_TIMEOUT_LIMIT && rx_pos_q == tmo_at) begin
						send_beat(bls_pkg::CMD_TIMEOUT, rnd_byte());
					end else if (kind == S_RESTART && !restart_done && rx_pos_q == restart_at) begin
						restart_done = 1'b1;
						send_beat(bls_pkg::CMD_START, rnd_byte());
					end else if (k == 0) begin
						send_beat(bls_pkg::CMD_TX_REQ, rnd_byte());
					end else if (k == 1 && first_seen_q && tmo_cnt_q < tmo_lim_q) begin
						send_beat(bls_pkg::CMD_TIMEOUT, rnd_byte());
					end else begin
						send_beat(bls_pkg::CMD_RX_BYTE, {7'($urandom), lfsr_q[0]});
					end
				end
				bls_pkg::PH_VER: begin
					if (k == 0)
						send_beat(bls_pkg::CMD_TIMEOUT, rnd_byte());
					else if (k == 1)
						send_beat(bls_pkg::CMD_TX_REQ, rnd_byte());
					else
						send_beat(bls_pkg::CMD_RX_BYTE, {7'($urandom), ver_val[rx_pos_q]});
				end
				default: send_beat(bls_pkg::CMD_START, rnd_byte());
			endcase
		end
		repeat ($urandom_range(1, 4))
			send_beat(bls_pkg::cmd_t'(2'($urandom_range(1, 3))), rnd_byte());
	endtask

	always @(posedge clk) begin
		bls_pkg::result_t due;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (handshake_results_due.size() == 0) begin
				$error("result beat with no expectation pending");
				fail_count++;
			end else begin
				due = handshake_results_due.pop_front();
				if (res_bus.tx_byte !== due.tx_byte) begin
					$error("tx_byte: expected %0h, got %0h", due.tx_byte, res_bus.tx_byte);
					fail_count++;
				end
				if (res_bus.tx_valid !== due.tx_valid) begin
					$error("tx_valid: expected %0b, got %0b", due.tx_valid, res_bus.tx_valid);
					fail_count++;
				end
				if (res_bus.reset_request !== due.reset_request) begin
					$error("reset_request: expected %0b, got %0b", due.reset_request,
						res_bus.reset_request);
					fail_count++;
				end
				if (res_bus.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, res_bus.status);
					fail_count++;
				end
				if (res_bus.version !== due.version) begin
					$error("version: expected %0h, got %0h", due.version, res_bus.version);
					fail_count++;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		int beats_taken;
		bit rx_quiet;
		res_bus.ready <= 1'b0;
		beats_taken = 0;
		rx_quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if (beats_taken % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			if (hold_off) begin
				stall = 300;
				hold_off = 1'b0;
			end else begin
				stall = rx_quiet ? 0 : $urandom_range(0, 17);
			end
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
			beats_taken++;
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int retry_val;
		int tmo_val;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bls_pkg::CFG_RETRY_LIMIT;
		cfg_wdata <= 8'h00;
		cmd_bus.valid <= 1'b0;
		cmd_bus.command <= bls_pkg::CMD_START;
		cmd_bus.rx_byte <= 8'h00;
		fail_count = 0;
		beats_sent = 0;
		tx_quiet = 1'b0;
		hold_off = 1'b0;
		retry_lim_q = bls_pkg::RETRY_LIMIT_RST;
		tmo_lim_q = bls_pkg::TIMEOUT_LIMIT_RST;
		lfsr_q = bls_pkg::LFSR_SEED;
		phase_q = bls_pkg::PH_IDLE;
		tx_pos_q = 0;
		rx_pos_q = 0;
		tmo_cnt_q = '0;
		retries_q = '0;
		ver_shift_q = '0;
		first_seen_q = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(bls_pkg::CFG_RETRY_LIMIT, 8'(bls_pkg::RETRY_LIMIT_RST));
		write_reg(bls_pkg::CFG_TIMEOUT_LIMIT, bls_pkg::TIMEOUT_LIMIT_RST);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].cmd, dir_rows[i].rxb, dir_rows[i].typed, dir_rows[i].want);
		foreach (plan_kind[s]) begin
			wait_idle();
			retry_val = (plan_retry[s] == RANDOM_CFG) ? $urandom_range(0, 3) : plan_retry[s];
			tmo_val = (plan_tmo[s] == RANDOM_CFG) ? $urandom_range(0, 255) : plan_tmo[s];
			write_reg(bls_pkg::CFG_RETRY_LIMIT, 8'(retry_val));
			write_reg(bls_pkg::CFG_TIMEOUT_LIMIT, 8'(tmo_val));
			if (plan_kind[s] == S_FULL)
				hold_off = 1'b1;
			run_session(plan_kind[s]);
		end
		cmd_bus.valid <= 1'b0;
		while (handshake_results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
